FILE: hw/rtl/mbtf_pkg.sv
// ----------------------------------------------------------------------------
// mbtf_pkg
// Types and constants shared by the Modbus TCP request framer.
// ----------------------------------------------------------------------------
package mbtf_pkg;

  localparam logic [2:0] CMD_RD_COILS  = 3'd0;
  localparam logic [2:0] CMD_RD_INPUTS = 3'd1;
  localparam logic [2:0] CMD_RD_HOLD   = 3'd2;
  localparam logic [2:0] CMD_RD_IREGS  = 3'd3;
  localparam logic [2:0] CMD_WR_COIL   = 3'd4;
  localparam logic [2:0] CMD_WR_REG    = 3'd5;
  localparam logic [2:0] CMD_WR_COILS  = 3'd6;
  localparam logic [2:0] CMD_WR_REGS   = 3'd7;

  localparam logic [7:0] FUNC_CODE [8] = '{
    8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd15, 8'd16
  };

  localparam logic [10:0] LIM_READ_BITS   = 11'd2000;
  localparam logic [10:0] LIM_READ_REGS   = 11'd125;
  localparam logic [10:0] LIM_WRITE_COILS = 11'd1968;
  localparam logic [10:0] LIM_WRITE_REGS  = 11'd123;

  localparam logic [7:0]  FRAME_LEN_SHORT = 8'd6;
  localparam logic [7:0]  FRAME_LEN_MULTI = 8'd7;
  localparam logic [15:0] COIL_ON         = 16'hFF00;
  localparam logic [7:0]  UNIT_ID_RESET   = 8'd1;
  localparam logic [15:0] TID_RESET       = 16'd1;

  // byte positions inside a frame
  localparam logic [3:0] POS_TAIL_LO = 4'd11;
  localparam logic [3:0] POS_NBYTES  = 4'd12;
  localparam logic [3:0] POS_ELEM    = 4'd13;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] start_address;
    logic [10:0] quantity;
    logic [15:0] data_word;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
    logic       rejected;
  } res_t;

  typedef enum logic [1:0] {
    JOB_REJECT,
    JOB_FRAME,
    JOB_MULTI,
    JOB_ELEM
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] tid;
    logic [7:0]  len;
    logic [7:0]  fc;
    logic [15:0] addr;
    logic [15:0] tail;
    logic [7:0]  nbytes;
    logic [1:0]  nelem;
    logic [7:0]  elem_hi;
    logic [7:0]  elem_lo;
    logic        elem_last;
  } job_t;

endpackage

FILE: hw/rtl/mbtf_front.sv
// ----------------------------------------------------------------------------
// mbtf_front
// Accepts request items, checks limits, tracks frame state and posts jobs.
// ----------------------------------------------------------------------------
module mbtf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mbtf_pkg::req_t req,
  input  logic          q_full,
  output logic          push,
  output mbtf_pkg::job_t job
);
  import mbtf_pkg::*;

  logic [15:0] transaction_id;
  logic        in_payload;
  logic [10:0] element_count;
  logic [7:0]  coil_byte;
  logic [10:0] pend_total;
  logic        pend_coils;

  logic        acc;
  logic [10:0] lim;
  logic        is_single;
  logic        is_multi;
  logic        over;
  logic [10:0] eff_idx;
  logic [10:0] eff_total;
  logic        eff_coils;
  logic [7:0]  eff_cb;
  logic        elem_last;
  logic [7:0]  cb_new;
  logic        coil_flush;
  logic [7:0]  nbytes;
  logic [7:0]  coil_byte_next;

  assign req_stall = q_full;
  assign acc       = req_valid && !req_stall;

  always_comb begin
    unique case (req.cmd) inside
      CMD_RD_COILS, CMD_RD_INPUTS: lim = LIM_READ_BITS;
      CMD_RD_HOLD, CMD_RD_IREGS:   lim = LIM_READ_REGS;
      CMD_WR_COILS:                lim = LIM_WRITE_COILS;
      CMD_WR_REGS:                 lim = LIM_WRITE_REGS;
      default:                     lim = '0;
    endcase
  end

  always_comb begin
    is_single = (req.cmd == CMD_WR_COIL) || (req.cmd == CMD_WR_REG);
    is_multi  = (req.cmd == CMD_WR_COILS) || (req.cmd == CMD_WR_REGS);
    over      = !is_single && ((req.quantity == '0) || (req.quantity > lim));

    eff_idx   = in_payload ? element_count : '0;
    eff_total = in_payload ? pend_total : req.quantity;
    eff_coils = in_payload ? pend_coils : (req.cmd == CMD_WR_COILS);
    eff_cb    = in_payload ? coil_byte : '0;

    elem_last  = ({1'b0, eff_idx} + 12'd1) >= {1'b0, eff_total};
    cb_new     = eff_cb | ({7'b0, req.data_word[0]} << eff_idx[2:0]);
    coil_flush = (eff_idx[2:0] == 3'd7) || elem_last;
    coil_byte_next = coil_flush ? 8'd0 : cb_new;

    if (req.cmd == CMD_WR_COILS) begin
      nbytes = 8'(({1'b0, req.quantity} + 12'd7) >> 3);
    end else begin
      nbytes = 8'({req.quantity, 1'b0});
    end

    job.tid       = transaction_id;
    job.fc        = FUNC_CODE[req.cmd];
    job.addr      = req.start_address;
    job.len       = FRAME_LEN_SHORT;
    job.tail      = {5'b0, req.quantity};
    job.nbytes    = nbytes;
    job.elem_last = elem_last;
    if (eff_coils) begin
      job.nelem   = coil_flush ? 2'd1 : 2'd0;
      job.elem_hi = '0;
      job.elem_lo = cb_new;
    end else begin
      job.nelem   = 2'd2;
      job.elem_hi = req.data_word[15:8];
      job.elem_lo = req.data_word[7:0];
    end

    if (in_payload) begin
      job.kind = JOB_ELEM;
      push     = acc && (job.nelem != 2'd0);
    end else if (over) begin
      job.kind = JOB_REJECT;
      push     = acc;
    end else if (is_multi) begin
      job.kind = JOB_MULTI;
      job.len  = nbytes + FRAME_LEN_MULTI;
      push     = acc;
    end else begin
      job.kind = JOB_FRAME;
      push     = acc;
      if (req.cmd == CMD_WR_COIL) begin
        job.tail = req.data_word[0] ? COIL_ON : 16'h0000;
      end else if (req.cmd == CMD_WR_REG) begin
        job.tail = req.data_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transaction_id <= TID_RESET;
      in_payload     <= 1'b0;
      element_count  <= '0;
      coil_byte      <= '0;
      pend_total     <= '0;
      pend_coils     <= 1'b0;
    end else if (acc) begin
      if (in_payload) begin
        element_count <= eff_idx + 11'd1;
        in_payload    <= !elem_last;
        if (pend_coils) begin
          coil_byte <= coil_byte_next;
        end
      end else if (!over) begin
        transaction_id <= transaction_id + 16'd1;
        if (is_multi) begin
          pend_total    <= req.quantity;
          pend_coils    <= eff_coils;
          element_count <= 11'd1;
          in_payload    <= !elem_last;
          coil_byte     <= eff_coils ? coil_byte_next : 8'd0;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    acc && !in_payload && over |=> $stable(transaction_id))
    else $error("transaction id moved on a rejected request");

  assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (element_count < pend_total))
    else $error("element count ran past the pending quantity");

  assert property (@(posedge clk) disable iff (rst)
    in_payload && !pend_coils |-> (coil_byte == 8'd0))
    else $error("coil byte dirty during a register payload");

  assert property (@(posedge clk) disable iff (rst)
    push && (job.kind == JOB_REJECT) |-> !in_payload)
    else $error("rejection posted inside a payload");

endmodule

FILE: hw/rtl/mbtf_queue.sv
// ----------------------------------------------------------------------------
// mbtf_queue
// Small job queue between the request front end and the byte back end.
// ----------------------------------------------------------------------------
module mbtf_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mbtf_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output mbtf_pkg::job_t head
);
  import mbtf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          store [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into a full queue");

  assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("pop from an empty queue");

  assert property (@(posedge clk) disable iff (rst) push && !pop |=> valid)
    else $error("queue empty after a push");

endmodule

FILE: hw/rtl/mbtf_back.sv
// ----------------------------------------------------------------------------
// mbtf_back
// Walks the head job byte by byte into the result output register.
// ----------------------------------------------------------------------------
module mbtf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     unit_id,
  input  logic           q_valid,
  input  mbtf_pkg::job_t head,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_stall,
  output mbtf_pkg::res_t res
);
  import mbtf_pkg::*;

  logic [3:0] pos;
  logic [3:0] idx;
  logic [3:0] end_idx;
  logic       is_end;
  logic       advance;
  logic       emit;
  res_t       res_next;

  assign advance = !res_valid || !res_stall;
  assign emit    = advance && q_valid;
  assign pop     = emit && is_end;

  always_comb begin
    idx = (head.kind == JOB_ELEM) ? 4'(pos + POS_ELEM) : pos;
    unique case (head.kind)
      JOB_REJECT: end_idx = 4'd0;
      JOB_FRAME:  end_idx = POS_TAIL_LO;
      default:    end_idx = 4'(POS_NBYTES + {2'b0, head.nelem});
    endcase
    is_end = (idx == end_idx);

    case (idx)
      4'd0:    res_next.out_byte = head.tid[15:8];
      4'd1:    res_next.out_byte = head.tid[7:0];
      4'd5:    res_next.out_byte = head.len;
      4'd6:    res_next.out_byte = unit_id;
      4'd7:    res_next.out_byte = head.fc;
      4'd8:    res_next.out_byte = head.addr[15:8];
      4'd9:    res_next.out_byte = head.addr[7:0];
      4'd10:   res_next.out_byte = head.tail[15:8];
      4'd11:   res_next.out_byte = head.tail[7:0];
      4'd12:   res_next.out_byte = head.nbytes;
      4'd13:   res_next.out_byte = (head.nelem == 2'd2) ? head.elem_hi : head.elem_lo;
      4'd14:   res_next.out_byte = head.elem_lo;
      default: res_next.out_byte = 8'd0;
    endcase

    res_next.rejected   = (head.kind == JOB_REJECT);
    if (head.kind == JOB_REJECT) begin
      res_next.out_byte = 8'd0;
    end
    res_next.frame_last = is_end &&
      ((head.kind == JOB_REJECT) || (head.kind == JOB_FRAME) || head.elem_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
        pos       <= is_end ? 4'd0 : pos + 4'd1;
      end else if (advance) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.rejected |-> res.frame_last && (res.out_byte == 8'd0))
    else $error("malformed rejection result");

  assert property (@(posedge clk) disable iff (rst) (pos != 4'd0) |-> q_valid)
    else $error("job vanished mid frame");

  assert property (@(posedge clk) disable iff (rst) q_valid |-> (idx <= end_idx))
    else $error("byte position ran past end of job");

endmodule

FILE: hw/rtl/modbus_tcp_request_framer.sv
// ----------------------------------------------------------------------------
// modbus_tcp_request_framer
// Builds Modbus TCP request frames (MBAP header and PDU) one byte per word.
// ----------------------------------------------------------------------------
// Results leave from a single output register at one byte per cycle while
// a job waits and res_stall is low. A read or single write frame is 12 bytes,
// the first item of a multiple write 13 to 15, each further register 2 and
// each further coil 1 or 0 (a byte goes out after eight coils or the last one).
// The front end accepts an item per cycle while the job queue of
// QUEUE_DEPTH entries has room; it stalls only when the queue is full.
module modbus_tcp_request_framer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_data,
  input  logic           req_valid,
  output logic           req_stall,
  input  mbtf_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_stall,
  output mbtf_pkg::res_t res
);
  import mbtf_pkg::*;

  logic [7:0] unit_id;
  logic       push;
  job_t       push_job;
  logic       q_full;
  logic       pop;
  logic       q_valid;
  job_t       head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_id <= UNIT_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unit_id <= cfg_data;
    end
  end

  mbtf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  mbtf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (head)
  );

  mbtf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .unit_id   (unit_id),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

FILE: verif/mbtf_frame_checker.sv
// ----------------------------------------------------------------------------
// mbtf_frame_checker
// Watches the request, result and unit id channels of the request framer.
// Builds the expected byte stream of every accepted request word and compares
// each accepted result word against it, field by field and in order.
// ----------------------------------------------------------------------------
module mbtf_frame_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [7:0]     cfg_data,
  input  logic           req_valid,
  input  logic           req_stall,
  input  mbtf_pkg::req_t req,
  input  logic           res_valid,
  input  logic           res_stall,
  input  mbtf_pkg::res_t res,
  output int             errors,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbtf_pkg::*;

  logic [7:0]  unit_id;
  logic [15:0] tid;
  logic        in_payload;
  logic [10:0] elem_count;
  logic [10:0] frame_qty;
  logic        frame_coils;
  logic [7:0]  coil_acc;
  res_t        expected_bytes[$];
  res_t        want;

  task automatic push_byte(input logic [7:0] b, input logic last);
    res_t e;
    e.out_byte   = b;
    e.frame_last = last;
    e.rejected   = 1'b0;
    expected_bytes.push_back(e);
  endtask

  task automatic push_header(input logic [15:0] len, input logic [2:0] cmd,
                             input logic [15:0] addr);
    push_byte(tid[15:8], 1'b0);
    push_byte(tid[7:0], 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(len[15:8], 1'b0);
    push_byte(len[7:0], 1'b0);
    push_byte(unit_id, 1'b0);
    push_byte(FUNC_CODE[cmd], 1'b0);
    push_byte(addr[15:8], 1'b0);
    push_byte(addr[7:0], 1'b0);
    tid = tid + 16'd1;
  endtask

  task automatic add_element(input logic [15:0] value);
    logic [10:0] idx;
    logic        last;
    idx  = elem_count;
    last = (int'(idx) + 1 >= int'(frame_qty));
    elem_count = idx + 11'd1;
    if (last) begin
      in_payload = 1'b0;
    end
    if (!frame_coils) begin
      push_byte(value[15:8], 1'b0);
      push_byte(value[7:0], last);
    end else begin
      if (value[0]) begin
        coil_acc[idx[2:0]] = 1'b1;
      end
      if (idx[2:0] == 3'd7 || last) begin
        push_byte(coil_acc, last);
        coil_acc = 8'h00;
      end
    end
  endtask

  function automatic logic [10:0] qty_limit(input logic [2:0] cmd);
    case (cmd)
      CMD_RD_COILS, CMD_RD_INPUTS: return LIM_READ_BITS;
      CMD_RD_HOLD, CMD_RD_IREGS:   return LIM_READ_REGS;
      CMD_WR_COILS:                return LIM_WRITE_COILS;
      CMD_WR_REGS:                 return LIM_WRITE_REGS;
      default:                     return 11'd0;
    endcase
  endfunction

  task automatic frame_request(input req_t r);
    logic [15:0] value;
    logic [10:0] nbytes;
    res_t        rej;
    if (in_payload) begin
      add_element(r.data_word);
      return;
    end
    if (r.cmd != CMD_WR_COIL && r.cmd != CMD_WR_REG &&
        (r.quantity == 11'd0 || r.quantity > qty_limit(r.cmd))) begin
      rej.out_byte   = 8'h00;
      rej.frame_last = 1'b1;
      rej.rejected   = 1'b1;
      expected_bytes.push_back(rej);
      return;
    end
    case (r.cmd)
      CMD_RD_COILS, CMD_RD_INPUTS, CMD_RD_HOLD, CMD_RD_IREGS: begin
        push_header({8'h00, FRAME_LEN_SHORT}, r.cmd, r.start_address);
        push_byte({5'b0, r.quantity[10:8]}, 1'b0);
        push_byte(r.quantity[7:0], 1'b1);
      end
      CMD_WR_COIL, CMD_WR_REG: begin
        if (r.cmd == CMD_WR_COIL) begin
          value = r.data_word[0] ? COIL_ON : 16'h0000;
        end else begin
          value = r.data_word;
        end
        push_header({8'h00, FRAME_LEN_SHORT}, r.cmd, r.start_address);
        push_byte(value[15:8], 1'b0);
        push_byte(value[7:0], 1'b1);
      end
      default: begin
        if (r.cmd == CMD_WR_COILS) begin
          nbytes = (r.quantity + 11'd7) >> 3;
        end else begin
          nbytes = r.quantity << 1;
        end
        push_header(16'(FRAME_LEN_MULTI) + 16'(nbytes), r.cmd, r.start_address);
        push_byte({5'b0, r.quantity[10:8]}, 1'b0);
        push_byte(r.quantity[7:0], 1'b0);
        push_byte(nbytes[7:0], 1'b0);
        frame_coils = (r.cmd == CMD_WR_COILS);
        frame_qty   = r.quantity;
        elem_count  = 11'd0;
        coil_acc    = 8'h00;
        in_payload  = 1'b1;
        add_element(r.data_word);
      end
    endcase
  endtask

  task automatic flag_error(input string what, input res_t exp, input res_t act);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected byte %02h last %0b rej %0b, got byte %02h last %0b rej %0b",
               $realtime, what, exp.out_byte, exp.frame_last, exp.rejected,
               act.out_byte, act.frame_last, act.rejected);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      unit_id     = UNIT_ID_RESET;
      tid         = TID_RESET;
      in_payload  = 1'b0;
      elem_count  = 11'd0;
      frame_qty   = 11'd0;
      frame_coils = 1'b0;
      coil_acc    = 8'h00;
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        unit_id = cfg_data;
      end
      if (res_valid && !res_stall) begin
        if (expected_bytes.size() == 0) begin
          flag_error("unexpected word", '0, res);
        end else begin
          want = expected_bytes.pop_front();
          if (res.out_byte !== want.out_byte || res.frame_last !== want.frame_last ||
              res.rejected !== want.rejected) begin
            flag_error("mismatch", want, res);
          end
        end
      end
      if (req_valid && !req_stall) begin
        frame_request(req);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the Modbus TCP request framer.
// A directed pass covers command extremes, rejections and short multiple
// writes; four random phases run with different unit ids and with sender
// gaps, result stalls, both or none; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbtf_pkg::*;

  localparam int PHASE_ITEMS    = 80;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic       req_valid = 1'b0;
  req_t       req = '0;
  logic       res_stall = 1'b0;
  logic       cfg_ready;
  logic       req_stall;
  logic       res_valid;
  res_t       res;
  int         errors;
  int         pending;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         items_sent = 0;
  int         quiet = 0;

  always #5 clk = ~clk;

  modbus_tcp_request_framer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  mbtf_frame_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [10:0] qty_limit(input logic [2:0] cmd);
    case (cmd)
      CMD_RD_COILS, CMD_RD_INPUTS: return LIM_READ_BITS;
      CMD_RD_HOLD, CMD_RD_IREGS:   return LIM_READ_REGS;
      CMD_WR_COILS:                return LIM_WRITE_COILS;
      CMD_WR_REGS:                 return LIM_WRITE_REGS;
      default:                     return 11'd0;
    endcase
  endfunction

  function automatic req_t random_word();
    req_t r;
    r.cmd           = 3'($urandom);
    r.start_address = 16'($urandom);
    r.quantity      = 11'($urandom);
    r.data_word     = 16'($urandom);
    return r;
  endfunction

  task automatic send_word(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    items_sent++;
  endtask

  task automatic send_frame(input logic [2:0] cmd, input logic [15:0] addr,
                            input logic [10:0] qty, input logic [15:0] value);
    req_t r;
    r.cmd           = cmd;
    r.start_address = addr;
    r.quantity      = qty;
    r.data_word     = value;
    send_word(r);
  endtask

  // first word carries the header and the first element, the rest are elements with random filler
  task automatic send_multi(input logic [2:0] cmd, input logic [10:0] qty);
    send_frame(cmd, 16'($urandom), qty, 16'($urandom));
    repeat (int'(qty) - 1) send_word(random_word());
  endtask

  task automatic random_traffic(input int n_items);
    int         first;
    int         pick;
    logic [2:0] cmd;
    req_t       r;
    first = items_sent;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if ($urandom_range(0, 1) == 1) begin
          send_multi(CMD_WR_COILS, 11'($urandom_range(1, 20)));
        end else begin
          send_multi(CMD_WR_REGS, 11'($urandom_range(1, 6)));
        end
      end else if (pick < 75) begin
        r = random_word();
        cmd = 3'($urandom_range(0, 5));
        r.cmd = cmd;
        if (cmd != CMD_WR_COIL && cmd != CMD_WR_REG) begin
          case ($urandom_range(0, 3))
            0:       r.quantity = 11'd1;
            1:       r.quantity = qty_limit(cmd);
            default: r.quantity = 11'($urandom_range(1, qty_limit(cmd)));
          endcase
        end
        send_word(r);
      end else begin
        r = random_word();
        if (r.cmd == CMD_WR_COILS || r.cmd == CMD_WR_REGS) begin
          if ($urandom_range(0, 3) == 0) begin
            r.quantity = 11'd0;
          end else begin
            r.quantity = 11'($urandom_range(int'(qty_limit(r.cmd)) + 1, 2047));
          end
        end
        send_word(r);
      end
    end
  endtask

  task automatic write_unit_id(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  int         idle_by_phase[4]  = '{0, 50, 0, 30};
  int         stall_by_phase[4] = '{0, 0, 50, 30};
  logic [7:0] unit_by_phase[4];

  initial begin
    unit_by_phase = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset unit id, no idling
    send_frame(CMD_RD_COILS, 16'h0000, 11'd1, 16'h0000);
    send_frame(CMD_RD_INPUTS, 16'hFFFF, LIM_READ_BITS, 16'hFFFF);
    send_frame(CMD_RD_HOLD, 16'h1234, LIM_READ_REGS, 16'h0000);
    send_frame(CMD_RD_IREGS, 16'h00FF, 11'd1, 16'hAAAA);
    send_frame(CMD_WR_COIL, 16'hFF00, 11'd0, 16'h0001);
    send_frame(CMD_WR_COIL, 16'h0000, 11'd2047, 16'hFFFE);
    send_frame(CMD_WR_REG, 16'hFFFF, 11'd1, 16'hFFFF);
    send_frame(CMD_WR_REG, 16'h0000, 11'd0, 16'h0000);
    send_frame(CMD_RD_COILS, 16'h0001, 11'd0, 16'h5555);
    send_frame(CMD_RD_INPUTS, 16'h8000, LIM_READ_BITS + 11'd1, 16'h0000);
    send_frame(CMD_RD_HOLD, 16'h7FFF, LIM_READ_REGS + 11'd1, 16'h0000);
    send_frame(CMD_RD_IREGS, 16'h0000, 11'd2047, 16'h0000);
    send_frame(CMD_WR_COILS, 16'h0000, LIM_WRITE_COILS + 11'd1, 16'hFFFF);
    send_frame(CMD_WR_REGS, 16'h0000, LIM_WRITE_REGS + 11'd1, 16'hFFFF);
    send_frame(CMD_WR_REGS, 16'h0000, 11'd0, 16'hFFFF);
    send_multi(CMD_WR_REGS, 11'd1);
    send_multi(CMD_WR_COILS, 11'd1);
    send_multi(CMD_WR_COILS, 11'd3);
    send_multi(CMD_WR_REGS, 11'd2);
    settle();

    for (int p = 0; p < 4; p++) begin
      write_unit_id(unit_by_phase[p]);
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      random_traffic(PHASE_ITEMS);
      settle();
    end

    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: modbus_tcp_request_framer.f
hw/rtl/mbtf_pkg.sv
hw/rtl/mbtf_front.sv
hw/rtl/mbtf_queue.sv
hw/rtl/mbtf_back.sv
hw/rtl/modbus_tcp_request_framer.sv
verif/mbtf_frame_checker.sv
verif/tb_top.sv
